@@ design/swm_pkg.sv @@
// shared types and constants of the sliding window median filter
package swm_pkg;

	// default capacity of the window in samples
	localparam int DEF_MAX_WINDOW = 64;

	// width of one sample and of the window size register
	localparam int SAMPLE_W = 32;
	localparam int WSZ_W    = 7;

	// window size after reset
	localparam logic [WSZ_W-1:0] WSZ_RESET = 7'd3;

	// per-sample control handed from the top level to the sorted cell row
	typedef struct packed {
		logic                       update;
		logic                       rem_mode;
		logic signed [SAMPLE_W-1:0] sample;
	} swm_ctrl_t;

endpackage

@@ design/swm_cell.sv @@
// one cell of the sorted row: holds a sample and its arrival slot, shifts on insert and remove
module swm_cell #(
	parameter int TW = 6
) (
	input  logic                               clk,
	input  swm_pkg::swm_ctrl_t                 ctrl,
	input  logic                               valid,
	input  logic [TW-1:0]                      oldest,
	input  logic [TW-1:0]                      new_tag,
	input  logic                               rip,
	input  logic                               before_r,
	input  logic                               before_r_prev,
	input  logic                               le_next,
	input  logic                               lt_p_prev,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] val_prev,
	input  logic [TW-1:0]                      tag_prev,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] val_next,
	input  logic [TW-1:0]                      tag_next,
	output logic signed [swm_pkg::SAMPLE_W-1:0] val,
	output logic [TW-1:0]                      tag,
	output logic                               le,
	output logic                               match,
	output logic                               lt_p,
	output logic signed [swm_pkg::SAMPLE_W-1:0] nxt_val
);

	logic signed [swm_pkg::SAMPLE_W-1:0] val_q;
	logic [TW-1:0]                       tag_q;
	logic                                eq_p;
	logic signed [swm_pkg::SAMPLE_W-1:0] b_val_self;
	logic signed [swm_pkg::SAMPLE_W-1:0] b_val_prev;
	logic [TW-1:0]                       b_tag_self;
	logic [TW-1:0]                       b_tag_prev;
	logic [TW-1:0]                       nxt_tag;

	assign val = val_q;
	assign tag = tag_q;

	// compare against the new sample and spot the leaving sample
	assign le    = valid && (val_q <= ctrl.sample);
	assign match = ctrl.rem_mode && valid && (tag_q == oldest);

	// insert position, corrected when the leaving sample sits in the lower part
	assign lt_p = rip ? le_next : le;
	assign eq_p = !lt_p && lt_p_prev;

	// row after removal, seen at this place and one place lower
	assign b_val_self = before_r ? val_q : val_next;
	assign b_tag_self = before_r ? tag_q : tag_next;
	assign b_val_prev = before_r_prev ? val_prev : val_q;
	assign b_tag_prev = before_r_prev ? tag_prev : tag_q;

	// select kept, inserted or shifted entry
	always_comb begin
		priority if (lt_p) begin
			nxt_val = b_val_self;
			nxt_tag = b_tag_self;
		end else if (eq_p) begin
			nxt_val = ctrl.sample;
			nxt_tag = new_tag;
		end else begin
			nxt_val = b_val_prev;
			nxt_tag = b_tag_prev;
		end
	end

	// cell storage
	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			val_q <= nxt_val;
			tag_q <= nxt_tag;
		end
	end

endmodule

@@ design/swm_sorter.sv @@
// row of sorted cells with removal locator and median select
module swm_sorter #(
	parameter int N  = swm_pkg::DEF_MAX_WINDOW,
	parameter int WW = 7,
	parameter int TW = 6
) (
	input  logic                               clk,
	input  swm_pkg::swm_ctrl_t                 ctrl,
	input  logic [WW-1:0]                      fill_eff,
	input  logic [TW-1:0]                      oldest,
	input  logic [TW-1:0]                      new_tag,
	input  logic [TW-1:0]                      mid,
	output logic signed [swm_pkg::SAMPLE_W-1:0] median
);

	logic signed [swm_pkg::SAMPLE_W-1:0] vals     [N];
	logic signed [swm_pkg::SAMPLE_W-1:0] nxt_vals [N];
	logic [TW-1:0]                       tags     [N];
	logic [N-1:0]                        valid;
	logic [N-1:0]                        le;
	logic [N-1:0]                        match;
	logic [N-1:0]                        lt_p;
	logic [N-1:0]                        before_r;
	logic [TW-1:0]                       r_idx;
	logic                                found;
	logic                                rip;

	// position of the leaving sample as a binary index
	always_comb begin
		r_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (match[i]) begin
				r_idx = r_idx | TW'(i);
			end
		end
	end

	assign found = |match;
	assign rip   = |(match & le);

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic                                le_next;
			logic                                lt_p_prev;
			logic                                br_prev;
			logic signed [swm_pkg::SAMPLE_W-1:0] v_prev;
			logic signed [swm_pkg::SAMPLE_W-1:0] v_next;
			logic [TW-1:0]                       t_prev;
			logic [TW-1:0]                       t_next;

			assign valid[g]    = fill_eff > WW'(g);
			assign before_r[g] = !found || (TW'(g) < r_idx);

			// neighbour wiring, ends of the row tied off
			if (g == 0) begin : g_first
				assign lt_p_prev = 1'b1;
				assign br_prev   = 1'b1;
				assign v_prev    = vals[0];
				assign t_prev    = tags[0];
			end else begin : g_mid_lo
				assign lt_p_prev = lt_p[g-1];
				assign br_prev   = before_r[g-1];
				assign v_prev    = vals[g-1];
				assign t_prev    = tags[g-1];
			end
			if (g == N - 1) begin : g_last
				assign le_next = 1'b0;
				assign v_next  = vals[g];
				assign t_next  = tags[g];
			end else begin : g_mid_hi
				assign le_next = le[g+1];
				assign v_next  = vals[g+1];
				assign t_next  = tags[g+1];
			end

			swm_cell #(
				.TW(TW)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.valid        (valid[g]),
				.oldest       (oldest),
				.new_tag      (new_tag),
				.rip          (rip),
				.before_r     (before_r[g]),
				.before_r_prev(br_prev),
				.le_next      (le_next),
				.lt_p_prev    (lt_p_prev),
				.val_prev     (v_prev),
				.tag_prev     (t_prev),
				.val_next     (v_next),
				.tag_next     (t_next),
				.val          (vals[g]),
				.tag          (tags[g]),
				.le           (le[g]),
				.match        (match[g]),
				.lt_p         (lt_p[g]),
				.nxt_val      (nxt_vals[g])
			);
		end
	endgenerate

	// lower median of the updated row
	assign median = nxt_vals[mid];

endmodule

@@ design/sliding_window_median_core.sv @@
// top level of the sliding window median filter: handshakes, window control, result register
// a sample lands in the input register; as it advances into a full window, its median loads the result register
// throughput: one sample per cycle without a result stall; all cells compare and shift in parallel in one step
// a stall on the result side holds the input register and drops s_tready until the result drains
// reset: window size returns to 3, the window is empty, no result pending
// cell contents need no reset; only the fill count marks which cells hold samples
module sliding_window_median_core #(
	parameter int MAX_WINDOW = swm_pkg::DEF_MAX_WINDOW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: window_size
	input  logic                         cfg_we,
	input  logic [swm_pkg::WSZ_W-1:0]    cfg_wdata,
	// slave side
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,  // [31:0] sample
	input  logic                         s_tuser,  // [0] start_of_stream
	// master side
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata   // [31:0] median
);

	localparam int WW = $clog2(MAX_WINDOW + 1);
	localparam int TW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = (WW > swm_pkg::WSZ_W) ? WW : swm_pkg::WSZ_W;

	logic [swm_pkg::WSZ_W-1:0]           wsz_q;
	logic [WW-1:0]                       fill_q;
	logic [TW-1:0]                       oldest_q;
	logic                                v_s1;
	logic                                sos_s1;
	logic signed [swm_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                m_tvalid_q;
	logic [31:0]                         median_q;

	logic [CW-1:0]                       wsz_ext;
	logic [WW-1:0]                       w_eff;
	logic [TW-1:0]                       mid;
	logic [WW-1:0]                       fill_eff;
	logic [WW-1:0]                       fill_inc;
	logic [TW-1:0]                       old_eff;
	logic [WW-1:0]                       old_inc;
	logic                                rem_mode;
	logic                                has_res;
	logic                                advance;
	logic [TW-1:0]                       new_tag;
	logic signed [swm_pkg::SAMPLE_W-1:0] median;
	swm_pkg::swm_ctrl_t                  ctrl;

	// effective window size, zero taken as one and saturated at capacity
	assign wsz_ext = CW'(wsz_q);
	always_comb begin
		priority if (wsz_q == '0) begin
			w_eff = WW'(1);
		end else if (wsz_ext > CW'(MAX_WINDOW)) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = WW'(wsz_ext);
		end
	end
	assign mid = TW'((w_eff - WW'(1)) >> 1);

	// window state as seen by the sample in the input register
	assign fill_eff = sos_s1 ? '0 : fill_q;
	assign old_eff  = sos_s1 ? '0 : oldest_q;
	assign fill_inc = fill_eff + WW'(1);
	assign old_inc  = WW'(old_eff) + WW'(1);
	assign rem_mode = (fill_eff == w_eff);
	assign has_res  = rem_mode || (fill_inc == w_eff);
	assign new_tag  = rem_mode ? old_eff : TW'(fill_eff);

	// the input register moves on when the result slot is free or not needed
	assign advance  = v_s1 && (!has_res || !m_tvalid_q || m_tready);
	assign s_tready = !v_s1 || advance;

	assign ctrl.update   = advance;
	assign ctrl.rem_mode = rem_mode;
	assign ctrl.sample   = sample_s1;

	swm_sorter #(
		.N (MAX_WINDOW),
		.WW(WW),
		.TW(TW)
	) u_sorter (
		.clk     (clk),
		.ctrl    (ctrl),
		.fill_eff(fill_eff),
		.oldest  (old_eff),
		.new_tag (new_tag),
		.mid     (mid),
		.median  (median)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sos_s1    <= s_tuser;
			sample_s1 <= s_tdata;
		end
	end

	// window size register, fill count and oldest slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsz_q    <= swm_pkg::WSZ_RESET;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cfg_we) begin
			wsz_q    <= cfg_wdata;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (advance) begin
			if (rem_mode) begin
				fill_q   <= fill_eff;
				oldest_q <= (old_inc == w_eff) ? '0 : TW'(old_inc);
			end else begin
				fill_q   <= fill_inc;
				oldest_q <= '0;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && has_res) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			median_q <= median;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = median_q;

endmodule
